// ===== hdl/ket_pkg.sv =====
// ----------------------------------------------------------------------------
// ket_pkg
// Types and constants shared by the keyed entry table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ket_pkg;

    localparam int ID_W     = 64;
    localparam int KEY_ID_W = 32;
    localparam int KEY_W    = 64;
    localparam int ACT_W    = 5;
    localparam int KIND_W   = 2;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 104;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [ID_W-1:0]     client_id;
        logic [ID_W-1:0]     server_id;
        logic [KEY_ID_W-1:0] key_id;
        logic [KEY_W-1:0]    key_value;
    } req_t;

    typedef struct packed {
        logic                found;
        logic                no_space;
        logic [KEY_ID_W-1:0] out_key_id;
        logic [KEY_W-1:0]    out_key_value;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/ket_table.sv =====
// ----------------------------------------------------------------------------
// ket_table
// Entry storage with parallel match, first-match and first-free priority
// selection, write/update and read-out for one request per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_table
    import ket_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire req_t             req,
    input  wire logic [ACT_W-1:0] active_entries,
    output rsp_t                  rsp
);

    logic [ID_W-1:0]     client_reg [TABLE_DEPTH];
    logic [ID_W-1:0]     server_reg [TABLE_DEPTH];
    logic [KEY_ID_W-1:0] key_id_reg [TABLE_DEPTH];
    logic [KEY_W-1:0]    key_reg    [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] live;
    logic [TABLE_DEPTH-1:0] match;
    logic [TABLE_DEPTH-1:0] empty;
    logic [TABLE_DEPTH-1:0] match_first;
    logic [TABLE_DEPTH-1:0] free_first;
    logic [TABLE_DEPTH-1:0] wr_sel;
    logic                   hit;
    logic                   has_free;
    logic [KEY_ID_W-1:0]    rd_key_id;
    logic [KEY_W-1:0]       rd_key;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            live[i]  = (i < int'(active_entries));
            match[i] = live[i] && (client_reg[i] == req.client_id)
                       && (server_reg[i] == req.server_id);
            empty[i] = live[i] && (client_reg[i] == '0) && (server_reg[i] == '0)
                       && (key_id_reg[i] == '0) && (key_reg[i] == '0);
        end
    end

    // isolate lowest set bit
    assign match_first = match & (~match + TABLE_DEPTH'(1));
    assign free_first  = empty & (~empty + TABLE_DEPTH'(1));
    assign hit         = |match;
    assign has_free    = |empty;
    assign wr_sel      = hit ? match_first : free_first;

    always_comb
    begin
        rd_key_id = '0;
        rd_key    = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            rd_key_id = rd_key_id | (key_id_reg[i] & {KEY_ID_W{match_first[i]}});
            rd_key    = rd_key | (key_reg[i] & {KEY_W{match_first[i]}});
        end
    end

    always_comb
    begin
        rsp = '0;
        case (req.kind)
            KIND_WRITE:
            begin
                rsp.found    = hit;
                rsp.no_space = !hit && !has_free;
            end
            KIND_READ:
            begin
                rsp.found         = hit;
                rsp.out_key_id    = rd_key_id;
                rsp.out_key_value = rd_key;
            end
            KIND_QUERY:
            begin
                rsp.found = hit;
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                client_reg[i] <= '0;
                server_reg[i] <= '0;
                key_id_reg[i] <= '0;
                key_reg[i]    <= '0;
            end
        end
        else if (fire && (req.kind == KIND_WRITE))
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (wr_sel[i])
                begin
                    client_reg[i] <= req.client_id;
                    server_reg[i] <= req.server_id;
                    key_id_reg[i] <= req.key_id;
                    key_reg[i]    <= req.key_value;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ket_out_stage.sv =====
// ----------------------------------------------------------------------------
// ket_out_stage
// Result register with valid/ready handshake toward the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_out_stage
    import ket_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire rsp_t in_rsp,
    output logic      out_valid,
    input  wire logic out_ready,
    output rsp_t      out_rsp
);

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rsp_reg <= in_rsp;
        end
    end

    assign out_valid = valid_reg;
    assign out_rsp   = rsp_reg;

endmodule

`default_nettype wire

// ===== hdl/keyed_entry_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_entry_table_top
// Table of key entries keyed by client and server identifiers.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries requests: tuser holds the kind (write, read, query),
//   tdata the identifiers and payload. m_* stream returns one result per
//   request: found, no_space and the payload of a read hit.
//   cfg_* sets the number of active slots; write it only while idle.
// Path: a request accepted into the input register is compared against the
//   table and captured in the result register, then presented at m_tvalid.
// Throughput: one request per cycle while m_tready holds high; the whole table
//   is compared in parallel between the input and the result register, and a
//   write updates the table at the same edge the result is captured.
// Reset: all entries are cleared to zero and the active count returns to 16.
// Stall: when m_tready is low the result register holds, the input register
//   holds behind it and s_tready drops; no transfer is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_entry_table_top
    import ket_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [63:0] client_id, [127:64] server_id, [159:128] key_id, [223:160] key_value
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  wire logic [KIND_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] found, [1] no_space, [33:2] out_key_id, [97:34] out_key_value, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [ACT_W-1:0]      cfg_data
);

    logic             in_valid_reg;
    logic             in_valid_next;
    req_t             req_reg;
    logic [ACT_W-1:0] active_reg;
    logic             stage_ready;
    logic             advance;
    rsp_t             tbl_rsp;
    rsp_t             out_rsp;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && stage_ready;
    assign s_tready      = !in_valid_reg || stage_ready;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            active_reg   <= ACTIVE_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg.kind      <= kind_t'(s_tuser);
            req_reg.client_id <= s_tdata[63:0];
            req_reg.server_id <= s_tdata[127:64];
            req_reg.key_id    <= s_tdata[159:128];
            req_reg.key_value <= s_tdata[223:160];
        end
    end

    ket_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .req            (req_reg),
        .active_entries (active_reg),
        .rsp            (tbl_rsp)
    );

    ket_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (stage_ready),
        .in_rsp    (tbl_rsp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rsp   (out_rsp)
    );

    assign m_tdata = {6'b0, out_rsp.out_key_value, out_rsp.out_key_id,
                      out_rsp.no_space, out_rsp.found};

endmodule

`default_nettype wire
